>>> design/tsts_pkg.sv
// ----------------------------------------------------------------------------
// tsts_pkg
// shared types, constants and helpers of the time slice task scheduler
// ----------------------------------------------------------------------------
package tsts_pkg;

   localparam int NUM_TASKS = 4;
   localparam int TASK_W    = $clog2(NUM_TASKS);

   typedef logic [TASK_W-1:0] task_idx_type;
   typedef logic [1:0]        status_type;

   localparam task_idx_type LAST_TASK   = task_idx_type'(NUM_TASKS - 1);
   localparam logic [7:0]   SLICE_RESET = 8'd10;

   localparam status_type TS_READY   = 2'd0;
   localparam status_type TS_RUNNING = 2'd1;
   localparam status_type TS_BLOCKED = 2'd2;

   typedef struct packed {
      status_type  status;
      logic [15:0] delay;
      logic [7:0]  slice;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type RESET_ENTRY = '{status: TS_READY, delay: 16'd0, slice: SLICE_RESET};

   typedef struct packed {
      task_idx_type rd_addr;
      logic         wr_en;
      task_idx_type wr_addr;
      entry_type    wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP_RD,
      S_SCAN,
      S_WR_CUR,
      S_WR_NXT,
      S_TICK
   } sched_state_type;

   function automatic task_idx_type succ_idx(input task_idx_type i);
      return (i == LAST_TASK) ? '0 : task_idx_type'(i + 1'b1);
   endfunction

endpackage

>>> design/tsts_ram.sv
// ----------------------------------------------------------------------------
// tsts_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tsts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tsts_store.sv
// ----------------------------------------------------------------------------
// tsts_store
// per task entry memory; entries never written read as their reset value
// ----------------------------------------------------------------------------
module tsts_store (
   input  logic                 clock,
   input  logic                 reset,
   input  tsts_pkg::mem_req_type req,
   output tsts_pkg::entry_type   rd_entry
);
   import tsts_pkg::*;

   logic [NUM_TASKS-1:0] valid_ff;
   logic [NUM_TASKS-1:0] valid_in;
   task_idx_type         rd_addr_ff;
   logic [ENTRY_W-1:0]   ram_rd_data;

   tsts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_addr (req.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rd_addr_ff <= req.rd_addr;
   end

   assign rd_entry = valid_ff[rd_addr_ff] ? entry_type'(ram_rd_data) : RESET_ENTRY;

endmodule

>>> design/tsts_ctrl.sv
// ----------------------------------------------------------------------------
// tsts_ctrl
// sequencer: read, modify and write back task entries, round robin search
// ----------------------------------------------------------------------------
module tsts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic                  req_block_self,
   input  logic [15:0]           req_block_ticks,
   input  logic [7:0]            slice_len,
   output tsts_pkg::mem_req_type  mem_req,
   input  tsts_pkg::entry_type    rd_entry,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_task_idx,
   output logic                  rsp_switched,
   output logic [15:0]           rsp_woke_mask
);
   import tsts_pkg::*;

   sched_state_type      state_ff, state_in;
   task_idx_type         running_ff, running_in;
   task_idx_type         scan_ff, scan_in;
   task_idx_type         nxt_ff, nxt_in;
   logic                 blk_ff, blk_in;
   logic [15:0]          ticks_ff, ticks_in;
   entry_type            cur_ent_ff, cur_ent_in;
   entry_type            nxt_ent_ff, nxt_ent_in;
   entry_type            last_ent_ff, last_ent_in;
   logic                 sw_ff, sw_in;
   logic [NUM_TASKS-1:0] woke_ff, woke_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           rsp_task_ff, rsp_task_in;
   logic                 rsp_sw_ff, rsp_sw_in;
   logic [15:0]          rsp_woke_ff, rsp_woke_in;

   // decoded conditions
   entry_type            step_ent;
   logic                 need_pick;
   logic                 scan_ready;
   logic                 scan_wrap;
   logic                 cur_keeps;
   entry_type            last_seen;
   entry_type            tick_ent;
   logic                 tick_wake;

   always_comb begin
      step_ent.status = blk_ff ? TS_BLOCKED : rd_entry.status;
      step_ent.delay  = blk_ff ? ticks_ff : rd_entry.delay;
      step_ent.slice  = (rd_entry.slice != 8'd0) ? 8'(rd_entry.slice - 8'd1) : 8'd0;
      need_pick       = (step_ent.slice == 8'd0) || (step_ent.status == TS_BLOCKED);

      scan_ready = (rd_entry.status == TS_READY);
      scan_wrap  = (succ_idx(scan_ff) == running_ff);
      cur_keeps  = (cur_ent_ff.status == TS_READY) || (cur_ent_ff.status == TS_RUNNING)
                   || (running_ff == LAST_TASK);
      last_seen  = (scan_ff == LAST_TASK) ? rd_entry : last_ent_ff;

      tick_ent  = rd_entry;
      tick_wake = 1'b0;
      if ((rd_entry.status == TS_BLOCKED) && (rd_entry.delay != 16'd0)) begin
         tick_ent.delay = 16'(rd_entry.delay - 16'd1);
         if (tick_ent.delay == 16'd0) begin
            tick_ent.status = TS_READY;
            tick_wake       = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = req_mode ? S_TICK : S_STEP_RD;
            end
         end
         S_STEP_RD: begin
            state_in = need_pick ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            if (scan_ready || scan_wrap) begin
               state_in = S_WR_CUR;
            end
         end
         S_WR_CUR: begin
            state_in = sw_ff ? S_WR_NXT : S_IDLE;
         end
         S_WR_NXT: begin
            state_in = S_IDLE;
         end
         S_TICK: begin
            if (scan_ff == LAST_TASK) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_req      = '0;
      running_in   = running_ff;
      scan_in      = scan_ff;
      nxt_in       = nxt_ff;
      blk_in       = blk_ff;
      ticks_in     = ticks_ff;
      cur_ent_in   = cur_ent_ff;
      nxt_ent_in   = nxt_ent_ff;
      last_ent_in  = last_ent_ff;
      sw_in        = sw_ff;
      woke_in      = woke_ff;
      rsp_valid_in = 1'b0;
      rsp_task_in  = rsp_task_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_woke_in  = rsp_woke_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               blk_in   = req_block_self;
               ticks_in = req_block_ticks;
               woke_in  = '0;
               if (req_mode) begin
                  mem_req.rd_addr = '0;
                  scan_in         = '0;
               end else begin
                  mem_req.rd_addr = running_ff;
               end
            end
         end
         S_STEP_RD: begin
            cur_ent_in = step_ent;
            if (need_pick) begin
               mem_req.rd_addr = succ_idx(running_ff);
               scan_in         = succ_idx(running_ff);
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = running_ff;
               mem_req.wr_data = step_ent;
               rsp_valid_in    = 1'b1;
               rsp_task_in     = 4'(running_ff);
               rsp_sw_in       = 1'b0;
               rsp_woke_in     = '0;
            end
         end
         S_SCAN: begin
            last_ent_in = last_seen;
            if (scan_ready) begin
               sw_in      = 1'b1;
               nxt_in     = scan_ff;
               nxt_ent_in = rd_entry;
            end else if (scan_wrap) begin
               if (cur_keeps) begin
                  sw_in  = 1'b0;
                  nxt_in = running_ff;
               end else begin
                  sw_in      = 1'b1;
                  nxt_in     = LAST_TASK;
                  nxt_ent_in = last_seen;
               end
            end else begin
               mem_req.rd_addr = succ_idx(scan_ff);
               scan_in         = succ_idx(scan_ff);
            end
         end
         S_WR_CUR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = running_ff;
            mem_req.wr_data = cur_ent_ff;
            if (sw_ff) begin
               if (cur_ent_ff.status == TS_RUNNING) begin
                  mem_req.wr_data.status = TS_READY;
               end
            end else begin
               mem_req.wr_data.slice = slice_len;
               rsp_valid_in          = 1'b1;
               rsp_task_in           = 4'(running_ff);
               rsp_sw_in             = 1'b0;
               rsp_woke_in           = '0;
            end
         end
         S_WR_NXT: begin
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = nxt_ff;
            mem_req.wr_data       = nxt_ent_ff;
            mem_req.wr_data.status = TS_RUNNING;
            mem_req.wr_data.slice = slice_len;
            running_in            = nxt_ff;
            rsp_valid_in          = 1'b1;
            rsp_task_in           = 4'(nxt_ff);
            rsp_sw_in             = 1'b1;
            rsp_woke_in           = '0;
         end
         S_TICK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_ff;
            mem_req.wr_data = tick_ent;
            mem_req.rd_addr = succ_idx(scan_ff);
            scan_in         = succ_idx(scan_ff);
            if (tick_wake) begin
               woke_in[scan_ff] = 1'b1;
            end
            if (scan_ff == LAST_TASK) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = 4'(running_ff);
               rsp_sw_in    = 1'b0;
               rsp_woke_in  = 16'(woke_in);
            end
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      nxt_ff      <= nxt_in;
      blk_ff      <= blk_in;
      ticks_ff    <= ticks_in;
      cur_ent_ff  <= cur_ent_in;
      nxt_ent_ff  <= nxt_ent_in;
      last_ent_ff <= last_ent_in;
      sw_ff       <= sw_in;
      woke_ff     <= woke_in;
      rsp_task_ff <= rsp_task_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_woke_ff <= rsp_woke_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_task_idx  = rsp_task_ff;
   assign rsp_switched  = rsp_sw_ff;
   assign rsp_woke_mask = rsp_woke_ff;

endmodule

>>> design/time_slice_task_scheduler.sv
// ----------------------------------------------------------------------------
// time_slice_task_scheduler
// round robin task scheduler with a per task time slice
//
// a command is taken when start is high and busy is low. req_mode 0 is a
// scheduler step (req_block_self / req_block_ticks may block the running
// task first), req_mode 1 is a system tick that counts blocked delays down.
// every command gives exactly one result: rsp_valid is high for one cycle
// with rsp_task_idx, rsp_switched and rsp_woke_mask. the receiver
// cannot stall; the result register holds it for that one cycle only.
// task entries live in one ram with a registered read, walked by a sequencer:
// a plain step writes back the running entry, a search step also reads the
// following entries in turn, a tick rewrites every entry in turn. a new
// command may start in the cycle the result shows. csr_slice_len is written
// on a csr_valid / csr_ready transfer; the user must write it only while
// idle, the block itself does not enforce this. reset clears the sequencer,
// makes all tasks ready with a slice of 10 and a zero delay (per entry valid
// bits, no clearing pass), task 0 running.
// ----------------------------------------------------------------------------
module time_slice_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic        req_block_self,
   input  logic [15:0] req_block_ticks,
   output logic        rsp_valid,
   output logic [3:0]  rsp_task_idx,
   output logic        rsp_switched,
   output logic [15:0] rsp_woke_mask,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_slice_len
);
   import tsts_pkg::*;

   logic [7:0]  slice_len_ff;
   logic [7:0]  slice_len_in;
   mem_req_type mem_req;
   entry_type   rd_entry;

   assign csr_ready    = 1'b1;
   assign slice_len_in = (csr_valid && csr_ready) ? csr_slice_len : slice_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_len_ff <= SLICE_RESET;
      end else begin
         slice_len_ff <= slice_len_in;
      end
   end

   tsts_store u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (mem_req),
      .rd_entry (rd_entry)
   );

   tsts_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_block_self  (req_block_self),
      .req_block_ticks (req_block_ticks),
      .slice_len       (slice_len_ff),
      .mem_req         (mem_req),
      .rd_entry        (rd_entry),
      .rsp_valid       (rsp_valid),
      .rsp_task_idx    (rsp_task_idx),
      .rsp_switched    (rsp_switched),
      .rsp_woke_mask   (rsp_woke_mask)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the time slice task scheduler
//
// a behavioral scheduler model predicts current task, switch flag and wake
// mask for every command taken on start/busy; a monitor compares each
// rsp_valid transfer against the oldest prediction. directed tests cover
// slice expiry, blocking and waking, the idle fallback and the slice register
// extremes, then random traffic runs under several slice settings, half with
// bursty command issue. permanent blocks of ordinary tasks are left for last.
// ----------------------------------------------------------------------------
module tb;
   import tsts_pkg::*;

   localparam int SETTLE_CYCLES = NUM_TASKS + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [3:0]  cur;
      logic        sw;
      logic [15:0] woke;
   } sched_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic        req_block_self;
   logic [15:0] req_block_ticks;
   logic        rsp_valid;
   logic [3:0]  rsp_task_idx;
   logic        rsp_switched;
   logic [15:0] rsp_woke_mask;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_slice_len;

   // scheduler model state
   status_type  task_st  [NUM_TASKS];
   logic [15:0] task_dly [NUM_TASKS];
   logic [7:0]  task_slc [NUM_TASKS];
   int          run_idx;
   logic [7:0]  slice_cfg;

   sched_rsp_type sched_expect_q[$];
   int            err_count;
   int            cycle_count;
   int            burst_left;
   bit            gap_on;

   time_slice_task_scheduler i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_block_self  (req_block_self),
      .req_block_ticks (req_block_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_task_idx    (rsp_task_idx),
      .rsp_switched    (rsp_switched),
      .rsp_woke_mask   (rsp_woke_mask),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_slice_len   (csr_slice_len)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (err_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   function automatic sched_rsp_type predict_sched(input logic mode, input logic blk,
                                                   input logic [15:0] ticks);
      sched_rsp_type r;
      int cur;
      int nxt;
      int n;
      r = '0;
      if (mode) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            if (task_st[i] == TS_BLOCKED && task_dly[i] != 16'd0) begin
               task_dly[i] = task_dly[i] - 16'd1;
               if (task_dly[i] == 16'd0) begin
                  task_st[i] = TS_READY;
                  r.woke[i]  = 1'b1;
               end
            end
         end
      end else begin
         cur = run_idx;
         if (blk) begin
            task_st[cur]  = TS_BLOCKED;
            task_dly[cur] = ticks;
         end
         if (task_slc[cur] != 8'd0)
            task_slc[cur] = task_slc[cur] - 8'd1;
         if (task_slc[cur] == 8'd0 || task_st[cur] == TS_BLOCKED) begin
            // round robin search after the running task
            nxt = -1;
            n   = (cur + 1) % NUM_TASKS;
            while (n != cur && nxt < 0) begin
               if (task_st[n] == TS_READY)
                  nxt = n;
               n = (n + 1) % NUM_TASKS;
            end
            if (nxt < 0)
               nxt = (task_st[cur] == TS_READY || task_st[cur] == TS_RUNNING) ?
                     cur : NUM_TASKS - 1;
            if (nxt != cur) begin
               if (task_st[cur] == TS_RUNNING)
                  task_st[cur] = TS_READY;
               run_idx       = nxt;
               task_st[nxt]  = TS_RUNNING;
               task_slc[nxt] = slice_cfg;
               r.sw          = 1'b1;
            end else begin
               task_slc[cur] = slice_cfg;
            end
         end
      end
      r.cur = 4'(run_idx);
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      sched_rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (sched_expect_q.size() == 0) begin
            report_mismatch("result transfer with no pending command");
         end else begin
            exp_r = sched_expect_q.pop_front();
            if (rsp_task_idx !== exp_r.cur)
               report_mismatch($sformatf("task index %0d, expected %0d",
                                         rsp_task_idx, exp_r.cur));
            if (rsp_switched !== exp_r.sw)
               report_mismatch($sformatf("switched %0b, expected %0b",
                                         rsp_switched, exp_r.sw));
            if (rsp_woke_mask !== exp_r.woke)
               report_mismatch($sformatf("woke_mask %h, expected %h",
                                         rsp_woke_mask, exp_r.woke));
         end
      end
   end

   task automatic send_cmd(input logic mode, input logic blk, input logic [15:0] ticks);
      int gap;
      if (gap_on && burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(1, 8);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      start           = 1'b1;
      req_mode        = mode;
      req_block_self  = blk;
      req_block_ticks = ticks;
      do @(posedge clock); while (busy);
      sched_expect_q.push_back(predict_sched(mode, blk, ticks));
   endtask

   task automatic settle_idle();
      @(negedge clock);
      start = 1'b0;
      while (sched_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slice(input logic [7:0] value);
      settle_idle();
      @(negedge clock);
      csr_valid     = 1'b1;
      csr_slice_len = value;
      do @(posedge clock); while (!csr_ready);
      slice_cfg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random_item();
      int          pick;
      logic        blk;
      logic [15:0] ticks;
      pick  = $urandom_range(0, 99);
      ticks = 16'($urandom);
      if (pick < 35) begin
         // tick, block flag is don't care
         send_cmd(1'b1, 1'($urandom), ticks);
      end else begin
         blk = ($urandom_range(0, 99) < 30);
         if (blk) begin
            // endless or very long blocks only on the idle task, which the fallback recovers
            pick = $urandom_range(0, 99);
            if (run_idx == NUM_TASKS - 1) begin
               if (pick < 30)
                  ticks = 16'd0;
               else if (pick >= 55)
                  ticks = 16'($urandom_range(1, 8));
            end else begin
               ticks = (pick < 90) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(7, 200));
            end
         end
         send_cmd(1'b0, blk, ticks);
      end
   endtask

   task automatic test_slice_expiry();
      repeat (10) send_cmd(1'b0, 1'b0, 16'($urandom));
   endtask

   task automatic test_block_wake();
      send_cmd(1'b0, 1'b1, 16'd2);
      send_cmd(1'b1, 1'b1, 16'hFFFF);
      send_cmd(1'b1, 1'b0, 16'h0000);
   endtask

   task automatic test_idle_fallback();
      repeat (NUM_TASKS) send_cmd(1'b0, 1'b1, 16'd3);
      send_cmd(1'b1, 1'b0, 16'd0);
   endtask

   task automatic test_slice_extremes();
      write_slice(8'd0);
      repeat (3) send_cmd(1'b0, 1'b0, 16'd0);
      write_slice(8'd255);
      repeat (2) send_cmd(1'b0, 1'b0, 16'd0);
      write_slice(8'd1);
      repeat (2) send_cmd(1'b0, 1'b0, 16'd0);
   endtask

   task automatic test_random_traffic(input logic [7:0] slice, input int count, input bit gaps);
      write_slice(slice);
      gap_on     = gaps;
      burst_left = 0;
      repeat (count) send_random_item();
   endtask

   task automatic test_block_forever();
      write_slice(8'd4);
      gap_on = 1'b0;
      send_cmd(1'b0, 1'b1, 16'd0);
      send_cmd(1'b0, 1'b1, 16'hFFFF);
      repeat (4) send_cmd(1'b1, 1'b0, 16'd0);
      repeat (8) send_cmd(1'b0, 1'b0, 16'd0);
   endtask

   initial begin
      logic [7:0] slices [8];
      slices          = '{8'd1, 8'd2, 8'd3, 8'd10, 8'd255, 8'd0, 8'd5, 8'd4};
      slices[6]       = 8'($urandom_range(1, 255));
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = 1'b0;
      req_block_self  = 1'b0;
      req_block_ticks = 16'd0;
      csr_valid       = 1'b0;
      csr_slice_len   = 8'd0;
      err_count       = 0;
      cycle_count     = 0;
      burst_left      = 0;
      gap_on          = 1'b0;
      slice_cfg       = SLICE_RESET;
      run_idx         = 0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         task_st[i]  = TS_READY;
         task_dly[i] = 16'd0;
         task_slc[i] = SLICE_RESET;
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_slice_expiry();
      test_block_wake();
      test_idle_fallback();
      test_slice_extremes();
      for (int p = 0; p < 8; p++)
         test_random_traffic(slices[p], 230, p[0] == 1'b0);
      test_block_forever();
      settle_idle();

      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
